@@ rtl/lbb_pkg.sv @@
// ----------------------------------------------------------------------------
// lbb_pkg: shared types and constants for the LED blink/breathe generator
// Mode and register codes, configuration and result structs, sine table.
// ----------------------------------------------------------------------------
package lbb_pkg;

  // field widths
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ROM_AW   = 6;
  localparam int unsigned ROM_DEPTH = 64;

  // brightness levels
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

  // reset values of the period registers
  localparam logic [PERIOD_W-1:0] FAST_RST    = 16'd300;
  localparam logic [PERIOD_W-1:0] SLOW_RST    = 16'd800;
  localparam logic [PERIOD_W-1:0] BREATHE_RST = 16'd40;

  // output mode
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF     = 3'd0,
    MODE_ON      = 3'd1,
    MODE_SLOW    = 3'd2,
    MODE_FAST    = 3'd3,
    MODE_BREATHE = 3'd4
  } mode_e;

  // configuration register index
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 2'd0,
    REG_FAST    = 2'd1,
    REG_SLOW    = 2'd2,
    REG_BREATHE = 2'd3
  } cfg_idx_e;

  // configuration seen by the step logic
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [PERIOD_W-1:0] fast_half_period;
    logic [PERIOD_W-1:0] slow_half_period;
    logic [PERIOD_W-1:0] breathe_step_period;
    logic                mode_wr;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic [LEVEL_W-1:0] brightness;
    logic               update;
  } res_t;

  // one sine period, centred on mid scale
  localparam logic [LEVEL_W-1:0] SINE_ROM [ROM_DEPTH] = '{
    8'd128, 8'd140, 8'd153, 8'd165, 8'd177, 8'd188, 8'd199, 8'd209,
    8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
    8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226, 8'd218,
    8'd209, 8'd199, 8'd188, 8'd177, 8'd165, 8'd153, 8'd140, 8'd128,
    8'd128, 8'd116, 8'd103, 8'd91,  8'd79,  8'd68,  8'd57,  8'd47,
    8'd38,  8'd30,  8'd22,  8'd16,  8'd11,  8'd6,   8'd3,   8'd2,
    8'd2,   8'd3,   8'd6,   8'd11,  8'd16,  8'd22,  8'd30,  8'd38,
    8'd47,  8'd57,  8'd68,  8'd79,  8'd91,  8'd103, 8'd116, 8'd128
  };

  function automatic logic [LEVEL_W-1:0] sine_lookup(input logic [ROM_AW-1:0] idx);
    return SINE_ROM[idx];
  endfunction

endpackage

@@ rtl/lbb_if.sv @@
// ----------------------------------------------------------------------------
// lbb_in_if / lbb_out_if: valid/ready channels of the LED generator
// Time stamp channel in, brightness result channel out.
// ----------------------------------------------------------------------------
interface lbb_in_if;
  logic                       valid;
  logic                       ready;
  logic [lbb_pkg::NOW_W-1:0]  now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

interface lbb_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbb_pkg::LEVEL_W-1:0] brightness;
  logic                        update;

  modport source (output valid, output brightness, output update, input ready);
  modport sink   (input valid, input brightness, input update, output ready);
endinterface

@@ rtl/lbb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lbb_cfg_regs: configuration register file
// Mode and three period registers; zero period writes are dropped.
// ----------------------------------------------------------------------------
module lbb_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lbb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lbb_pkg::PERIOD_W-1:0]     cfg_data_i,
  output lbb_pkg::cfg_t                    cfg_o
);

  logic [lbb_pkg::MODE_W-1:0]   mode_q;
  logic [lbb_pkg::PERIOD_W-1:0] fast_q, slow_q, breathe_q;
  logic                         data_nz;

  assign data_nz = (cfg_data_i != '0);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= lbb_pkg::MODE_OFF;
      fast_q    <= lbb_pkg::FAST_RST;
      slow_q    <= lbb_pkg::SLOW_RST;
      breathe_q <= lbb_pkg::BREATHE_RST;
    end else if (cfg_we_i) begin
      case (lbb_pkg::cfg_idx_e'(cfg_idx_i))
        lbb_pkg::REG_MODE:    mode_q <= cfg_data_i[lbb_pkg::MODE_W-1:0];
        lbb_pkg::REG_FAST:    if (data_nz) fast_q <= cfg_data_i;
        lbb_pkg::REG_SLOW:    if (data_nz) slow_q <= cfg_data_i;
        lbb_pkg::REG_BREATHE: if (data_nz) breathe_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.mode                = mode_q;
    cfg_o.fast_half_period    = fast_q;
    cfg_o.slow_half_period    = slow_q;
    cfg_o.breathe_step_period = breathe_q;
    cfg_o.mode_wr             = cfg_we_i &&
                                (lbb_pkg::cfg_idx_e'(cfg_idx_i) == lbb_pkg::REG_MODE);
  end

endmodule

@@ rtl/lbb_step.sv @@
// ----------------------------------------------------------------------------
// lbb_step: pattern step logic and its state
// Elapsed time test, phase counter and level selection for one time stamp.
// ----------------------------------------------------------------------------
module lbb_step #(
  parameter int unsigned PHASE_STEPS = 64,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lbb_pkg::cfg_t                 cfg_i,
  input  logic                          step_i,
  input  logic [lbb_pkg::NOW_W-1:0]     now_i,
  output lbb_pkg::res_t                 res_o
);

  localparam int unsigned PHASE_W = $clog2(PHASE_STEPS);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_STEPS - 1);

  logic [TIME_WIDTH-1:0]        last_q, last_d;
  logic [PHASE_W-1:0]           phase_q, phase_d;
  logic [TIME_WIDTH-1:0]        now_t, diff;
  logic [lbb_pkg::PERIOD_W-1:0] period;
  logic                         elapsed;
  logic                         advance;

  // wrapping time since the last change
  assign now_t = TIME_WIDTH'(now_i);
  assign diff  = now_t - last_q;

  always_comb begin
    case (lbb_pkg::mode_e'(cfg_i.mode))
      lbb_pkg::MODE_FAST: period = cfg_i.fast_half_period;
      lbb_pkg::MODE_SLOW: period = cfg_i.slow_half_period;
      default:            period = cfg_i.breathe_step_period;
    endcase
  end

  assign elapsed = (diff >= TIME_WIDTH'(period));

  // level selection per mode
  always_comb begin
    res_o.brightness = lbb_pkg::LEVEL_OFF;
    res_o.update     = 1'b0;
    advance          = 1'b0;
    case (lbb_pkg::mode_e'(cfg_i.mode))
      lbb_pkg::MODE_OFF: begin
        res_o.update = 1'b1;
      end
      lbb_pkg::MODE_ON: begin
        res_o.brightness = lbb_pkg::LEVEL_FULL;
        res_o.update     = 1'b1;
      end
      lbb_pkg::MODE_SLOW, lbb_pkg::MODE_FAST: begin
        if (elapsed) begin
          res_o.brightness = phase_q[0] ? lbb_pkg::LEVEL_OFF : lbb_pkg::LEVEL_FULL;
          res_o.update     = 1'b1;
          advance          = 1'b1;
        end
      end
      lbb_pkg::MODE_BREATHE: begin
        if (elapsed) begin
          res_o.brightness = lbb_pkg::sine_lookup(lbb_pkg::ROM_AW'(phase_q));
          res_o.update     = 1'b1;
          advance          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state update: a mode write clears the change time
  always_comb begin
    last_d  = last_q;
    phase_d = phase_q;
    if (cfg_i.mode_wr) begin
      last_d = '0;
    end else if (step_i && advance) begin
      last_d  = now_t;
      phase_d = (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      phase_q <= '0;
    end else begin
      last_q  <= last_d;
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/led_blink_breathe_pattern_top.sv @@
// Path: an accepted time stamp waits in the input register; its result is
// loaded into the result register when the output is free.
// Throughput: one beat per cycle unless the output stalls; the step logic is
// a single subtract, compare and sine table read between the two registers.
// Reset: configuration returns to off mode with periods 300/800/40 ms, change
// time and phase clear to zero, both pipeline stages empty.
// ----------------------------------------------------------------------------
// led_blink_breathe_pattern_top: LED blink and breathe pattern generator
// Turns millisecond time stamps into brightness levels with update flags.
// ----------------------------------------------------------------------------
module led_blink_breathe_pattern_top #(
  parameter int unsigned PHASE_STEPS = 64,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lbb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lbb_pkg::PERIOD_W-1:0]   cfg_data_i,
  lbb_in_if.sink                         in_i,
  lbb_out_if.source                      out_o
);

  lbb_pkg::cfg_t cfg;
  lbb_pkg::res_t res, res_q;

  logic                         in_v_q;
  logic [lbb_pkg::NOW_W-1:0]    now_q;
  logic                         out_v_q;
  logic                         out_load;
  logic                         in_load;

  // handshake: result register frees up when empty or taken
  assign out_load = in_v_q && (!out_v_q || out_o.ready);
  assign in_load  = in_i.valid && in_i.ready;
  assign in_i.ready = !in_v_q || out_load;

  lbb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lbb_step #(
    .PHASE_STEPS (PHASE_STEPS),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (out_load),
    .now_i  (now_q),
    .res_o  (res)
  );

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      now_q <= in_i.now_ms;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.brightness = res_q.brightness;
  assign out_o.update     = res_q.update;

endmodule

@@ rtl/lbb_checker.sv @@
// ----------------------------------------------------------------------------
// lbb_checker: port level checks for the LED pattern generator
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lbb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [lbb_pkg::LEVEL_W-1:0]   brightness_i,
  input logic                          update_i
);

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a result with no update carries a zero level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !update_i |-> brightness_i == lbb_pkg::LEVEL_OFF)
    else $error("level set without update");

  // a new result follows an input beat held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result beat without input beat");

  // with an empty output the input side is never held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind led_blink_breathe_pattern_top lbb_checker u_lbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .brightness_i (out_o.brightness),
  .update_i     (out_o.update)
);
